// ===== rtl/multichannel_stereo_mixer_core_defines.svh =====
// Assertion helpers shared by the mixer RTL.
`ifndef MULTICHANNEL_STEREO_MIXER_CORE_DEFINES_SVH
`define MULTICHANNEL_STEREO_MIXER_CORE_DEFINES_SVH

// same-cycle implication
`define MSMIX_ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define MSMIX_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/msmix_pkg.sv =====
package msmix_pkg;

    typedef enum logic [0:0] {
        OP_MIX   = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_MASTER_VOLUME = 2'd0,
        REG_OUT_8BIT      = 2'd1,
        REG_MONO_OUT      = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic mix_en;
        logic flush_en;
        logic is_8bit;
    } chan_ctl_t;

    localparam logic [8:0]        MASTER_VOL_RESET = 9'd256;
    localparam logic signed [15:0] SAMPLE_MAX      = 16'sh7fff;
    localparam logic signed [15:0] SAMPLE_MIN      = 16'sh8000;
    localparam logic [7:0]        U8_OFFSET        = 8'd128;

endpackage

// ===== rtl/msmix_chan.sv =====
`include "multichannel_stereo_mixer_core_defines.svh"

module msmix_chan #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  msmix_pkg::chan_ctl_t    ctl,
    input  logic signed [15:0]      sample,
    input  logic [7:0]              vol,
    input  logic [8:0]              master_volume,
    input  logic                    out_8bit,
    output logic signed [15:0]      result
);

    logic signed [ACC_WIDTH-1:0]  acc_reg;
    logic signed [ACC_WIDTH-1:0]  acc_next;
    logic signed [ACC_WIDTH-1:0]  delta;

    logic signed [7:0]            s8;
    logic signed [8:0]            vol16;
    logic signed [8:0]            vol8;
    logic signed [24:0]           p16;
    logic signed [16:0]           p8;
    logic signed [15:0]           d16;

    logic signed [ACC_WIDTH+9:0]  prod;
    logic signed [ACC_WIDTH+1:0]  scaled;
    logic                         fits;
    logic signed [15:0]           clamped;
    logic [7:0]                   u8_val;

    // voice contribution
    always_comb begin
        s8    = sample[7:0];
        vol16 = $signed({1'b0, vol});
        vol8  = $signed({1'b0, vol[7:3], 3'b000});
        p16   = sample * vol16;
        p8    = s8 * vol8;
        d16   = p16[23:8];
        if (ctl.is_8bit) begin
            delta = {{(ACC_WIDTH-17){p8[16]}}, p8};
        end else begin
            delta = {{(ACC_WIDTH-16){d16[15]}}, d16};
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (ctl.flush_en) begin
            acc_next = '0;
        end else if (ctl.mix_en) begin
            acc_next = acc_reg + delta;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    // master gain, floor shift, clip, optional unsigned 8-bit conversion
    always_comb begin
        prod    = acc_reg * $signed({1'b0, master_volume});
        scaled  = prod[ACC_WIDTH+9:8];
        fits    = (&scaled[ACC_WIDTH+1:15]) | ~(|scaled[ACC_WIDTH+1:15]);
        if (fits) begin
            clamped = scaled[15:0];
        end else if (scaled[ACC_WIDTH+1]) begin
            clamped = msmix_pkg::SAMPLE_MIN;
        end else begin
            clamped = msmix_pkg::SAMPLE_MAX;
        end
        u8_val = clamped[15:8] + msmix_pkg::U8_OFFSET;
        if (out_8bit) begin
            result = $signed({8'h00, u8_val});
        end else begin
            result = clamped;
        end
    end

    `MSMIX_ASSERT_NEXT(a_flush_clears_acc, ctl.flush_en, acc_reg == '0, "accumulator not cleared by flush")
    `MSMIX_ASSERT_NEXT(a_acc_holds_idle, !ctl.flush_en && !ctl.mix_en, $stable(acc_reg), "accumulator moved without an item")

endmodule

// ===== rtl/multichannel_stereo_mixer_core.sv =====
// Stereo voice mixer. Mix items (s_op = 0) add one scaled voice sample to a
// left and a right accumulator; a flush item (s_op = 1) applies the master
// volume, clips to signed 16 bits (or converts to unsigned 8 bits), emits one
// result item and clears both accumulators. One item is taken every cycle
// unless a flush is stalled: an item lands in and is processed in the input
// register (accumulate, or gain and clip into the output register), so a
// flush reaches m_ through both registers. A flush waits in the input register only
// while an earlier result is still held in the output register and not taken.
// Registers via APB: 0x0 master_volume (9 bits, 256 = unity), 0x4 out_8bit,
// 0x8 mono_out (right output forced to zero); write them only while idle.
`include "multichannel_stereo_mixer_core_defines.svh"

module multichannel_stereo_mixer_core #(
    parameter int ACC_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic               s_sample_is_8bit,
    input  logic signed [15:0] s_sample,
    input  logic [7:0]         s_left_vol,
    input  logic [7:0]         s_right_vol,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_out_left,
    output logic signed [15:0] m_out_right
);

    logic [8:0]                master_volume_reg;
    logic                      out_8bit_reg;
    logic                      mono_out_reg;
    logic                      cfg_wr;

    logic                      in_valid_reg;
    logic                      in_valid_next;
    msmix_pkg::op_t            in_op_reg;
    logic                      in_is8_reg;
    logic signed [15:0]        in_sample_reg;
    logic [7:0]                in_left_vol_reg;
    logic [7:0]                in_right_vol_reg;

    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic signed [15:0]        m_out_left_reg;
    logic signed [15:0]        m_out_right_reg;

    logic                      out_free;
    logic                      advance;
    msmix_pkg::chan_ctl_t      ctl;
    logic signed [15:0]        left_result;
    logic signed [15:0]        right_result;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_volume_reg <= msmix_pkg::MASTER_VOL_RESET;
            out_8bit_reg      <= 1'b0;
            mono_out_reg      <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                msmix_pkg::REG_MASTER_VOLUME: master_volume_reg <= pwdata[8:0];
                msmix_pkg::REG_OUT_8BIT:      out_8bit_reg      <= pwdata[0];
                msmix_pkg::REG_MONO_OUT:      mono_out_reg      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            msmix_pkg::REG_MASTER_VOLUME: prdata = {23'd0, master_volume_reg};
            msmix_pkg::REG_OUT_8BIT:      prdata = {31'd0, out_8bit_reg};
            msmix_pkg::REG_MONO_OUT:      prdata = {31'd0, mono_out_reg};
            default:                      prdata = '0;
        endcase
    end

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && ((in_op_reg == msmix_pkg::OP_MIX) || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_comb begin
        ctl.mix_en   = in_valid_reg && (in_op_reg == msmix_pkg::OP_MIX);
        ctl.flush_en = in_valid_reg && (in_op_reg == msmix_pkg::OP_FLUSH) && out_free;
        ctl.is_8bit  = in_is8_reg;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.flush_en) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg        <= msmix_pkg::op_t'(s_op);
            in_is8_reg       <= s_sample_is_8bit;
            in_sample_reg    <= s_sample;
            in_left_vol_reg  <= s_left_vol;
            in_right_vol_reg <= s_right_vol;
        end
        if (ctl.flush_en) begin
            m_out_left_reg  <= left_result;
            m_out_right_reg <= mono_out_reg ? 16'sd0 : right_result;
        end
    end

    msmix_chan #(
        .ACC_WIDTH     (ACC_WIDTH)
    ) u_left (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .sample        (in_sample_reg),
        .vol           (in_left_vol_reg),
        .master_volume (master_volume_reg),
        .out_8bit      (out_8bit_reg),
        .result        (left_result)
    );

    msmix_chan #(
        .ACC_WIDTH     (ACC_WIDTH)
    ) u_right (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .sample        (in_sample_reg),
        .vol           (in_right_vol_reg),
        .master_volume (master_volume_reg),
        .out_8bit      (out_8bit_reg),
        .result        (right_result)
    );

    assign m_valid     = m_valid_reg;
    assign m_out_left  = m_out_left_reg;
    assign m_out_right = m_out_right_reg;

    `MSMIX_ASSERT_NEXT(a_flush_reaches_out, ctl.flush_en, m_valid_reg, "flushed frame not presented")
    `MSMIX_ASSERT_SAME(a_mono_right_zero, m_valid_reg && mono_out_reg, m_out_right_reg == 16'sd0, "right output not zero in mono mode")
    `MSMIX_ASSERT_SAME(a_u8_range, m_valid_reg && out_8bit_reg, m_out_left_reg[15:8] == 8'h00, "8-bit output out of range")
    `MSMIX_ASSERT_NEXT(a_flush_blocked_holds, in_valid_reg && !ctl.mix_en && !out_free, in_valid_reg, "blocked flush item dropped")

endmodule
